FILE: rtl/smfa_pkg.sv
// ----------------------------------------------------------------------------
// smfa_pkg
// Shared types and constants for the sign-magnitude Q32.32 fixed-point ALU.
// ----------------------------------------------------------------------------
package smfa_pkg;

  localparam int WHOLE_W     = 32;
  localparam int FRAC_W      = 32;
  localparam int MAG_W       = WHOLE_W + FRAC_W;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [2:0] {
    FN_ADD = 3'd0,
    FN_SUB = 3'd1,
    FN_MUL = 3'd2,
    FN_CMP = 3'd3,
    FN_NEG = 3'd4
  } func_t;

  // Two-bit signed encodings of the compare result.
  localparam logic [1:0] ORD_LT = 2'b11;
  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_GT = 2'b01;

  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
    logic               neg;
    logic               ovf;
    logic               unf;
    logic [1:0]         order;
  } res_t;

  typedef struct packed {
    mag_t mag;
    logic ovf;
    logic unf;
  } mul_t;

endpackage

FILE: rtl/smfa_lin.sv
// ----------------------------------------------------------------------------
// smfa_lin
// Add, subtract, compare and negate on sign-magnitude operands.
// ----------------------------------------------------------------------------
module smfa_lin (
  input  smfa_pkg::func_t func,
  input  smfa_pkg::mag_t  ma,
  input  logic            na,
  input  smfa_pkg::mag_t  mb,
  input  logic            nb,
  output smfa_pkg::res_t  res
);
  import smfa_pkg::*;

  logic             nb_eff;
  logic [MAG_W:0]   sum;
  logic             a_gt;
  logic             mag_eq;
  mag_t             dif_ab;
  mag_t             dif_ba;

  always_comb begin
    // Subtraction flips the sign of a nonzero second operand.
    nb_eff = nb;
    if (func == FN_SUB) begin
      nb_eff = (mb != '0) ? ~nb : 1'b0;
    end
    sum    = {1'b0, ma} + {1'b0, mb};
    a_gt   = (ma > mb);
    mag_eq = (ma == mb);
    dif_ab = ma - mb;
    dif_ba = mb - ma;

    res = '0;
    case (func)
      FN_ADD, FN_SUB: begin
        if (na == nb_eff) begin
          {res.whole, res.frac} = sum[MAG_W-1:0];
          res.neg = na;
          res.ovf = sum[MAG_W];
        end else if (!mag_eq) begin
          if (a_gt) begin
            {res.whole, res.frac} = dif_ab;
            res.neg = na;
          end else begin
            {res.whole, res.frac} = dif_ba;
            res.neg = nb_eff;
          end
        end
      end
      FN_CMP: begin
        if (na && !nb) begin
          res.order = ORD_LT;
        end else if (!na && nb) begin
          res.order = ORD_GT;
        end else if (mag_eq) begin
          res.order = ORD_EQ;
        end else if (a_gt) begin
          res.order = na ? ORD_LT : ORD_GT;
        end else begin
          res.order = na ? ORD_GT : ORD_LT;
        end
      end
      FN_NEG: begin
        {res.whole, res.frac} = ma;
        res.neg = (ma != '0) & ~na;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

FILE: rtl/smfa_mul.sv
// ----------------------------------------------------------------------------
// smfa_mul
// 64x64 magnitude multiplier: four registered 32x32 partial products,
// then a combine that keeps the middle 64 bits and raises the range flags.
// ----------------------------------------------------------------------------
module smfa_mul (
  input  logic           clk,
  input  logic           en,
  input  smfa_pkg::mag_t ma,
  input  smfa_pkg::mag_t mb,
  output smfa_pkg::mul_t res
);
  import smfa_pkg::*;

  localparam int HW = MAG_W / 2;
  localparam int PW = 2 * HW;

  logic [PW-1:0]   p0_next, p1_next, p2_next, p3_next;
  logic [PW-1:0]   p0, p1, p2, p3;
  logic [HW+1:0]   mid;
  logic [PW-1:0]   hi;

  always_comb begin
    p0_next = ma[HW-1:0]     * mb[HW-1:0];
    p1_next = ma[HW-1:0]     * mb[MAG_W-1:HW];
    p2_next = ma[MAG_W-1:HW] * mb[HW-1:0];
    p3_next = ma[MAG_W-1:HW] * mb[MAG_W-1:HW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= p0_next;
      p1 <= p1_next;
      p2 <= p2_next;
      p3 <= p3_next;
    end
  end

  // The true upper half of the product is below 2**64, so hi never carries out.
  always_comb begin
    mid = (HW+2)'(p0[PW-1:HW]) + (HW+2)'(p1[HW-1:0]) + (HW+2)'(p2[HW-1:0]);
    hi  = p3 + PW'(p1[PW-1:HW]) + PW'(p2[PW-1:HW]) + PW'(mid[HW+1:HW]);
    res.mag = {hi[HW-1:0], mid[HW-1:0]};
    res.ovf = |hi[PW-1:HW];
    res.unf = |p0[HW-1:0];
  end

endmodule

FILE: rtl/sign_magnitude_fixed_alu_core.sv
// ----------------------------------------------------------------------------
// sign_magnitude_fixed_alu_core
// Stateless Q32.32 sign-magnitude ALU: add, subtract, multiply, compare and
// negate, one operation per stream transaction.
// ----------------------------------------------------------------------------
// Pipeline: each transaction passes through the input register, the
// partial-product register of the multiplier and the output register.
// Throughput: one transaction per cycle, sustained; a stalled output only
// blocks the input once all three stages are full.
// Reset: rst is synchronous and active high; it empties all three stages.
// ----------------------------------------------------------------------------
module sign_magnitude_fixed_alu_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // func[2:0], a_whole[34:3], a_frac[66:35], a_neg[67],
  // b_whole[99:68], b_frac[131:100], b_neg[132], zero pad[135:133]
  input  logic [smfa_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // r_whole[31:0], r_frac[63:32], r_neg[64], overflow_flag[65],
  // underflow_flag[66], order[68:67] (signed), zero pad[71:69]
  output logic [smfa_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import smfa_pkg::*;

  // Stage 1: input register.
  logic  s1_vld;
  func_t s1_func;
  mag_t  s1_ma;
  logic  s1_na;
  mag_t  s1_mb;
  logic  s1_nb;

  // Stage 2: partial products (inside the multiplier) and the finished
  // result of every non-multiply operation.
  logic  s2_vld;
  func_t s2_func;
  res_t  s2_lin;
  logic  s2_mneg;

  // Stage 3: output register.
  res_t  out_q;

  // Per-stage ready: a stage may load when it is empty or its content moves on.
  logic  s3_rdy;
  logic  s2_rdy;
  logic  s1_rdy;

  res_t  lin_res;
  mul_t  mul_res;
  res_t  out_next;

  assign s3_rdy   = ~m_tvalid | m_tready;
  assign s2_rdy   = ~s2_vld | s3_rdy;
  assign s1_rdy   = ~s1_vld | s2_rdy;
  assign s_tready = s1_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld   <= 1'b0;
      s2_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_vld <= s_tvalid;
      end
      if (s2_rdy) begin
        s2_vld <= s1_vld;
      end
      if (s3_rdy) begin
        m_tvalid <= s2_vld;
      end
    end
  end

  // Input register: unpack the transaction into operands.
  always_ff @(posedge clk) begin
    if (s_tvalid && s1_rdy) begin
      s1_func <= func_t'(s_tdata[2:0]);
      s1_ma   <= {s_tdata[34:3], s_tdata[66:35]};
      s1_na   <= s_tdata[67];
      s1_mb   <= {s_tdata[99:68], s_tdata[131:100]};
      s1_nb   <= s_tdata[132];
    end
  end

  smfa_lin u_lin (
    .func (s1_func),
    .ma   (s1_ma),
    .na   (s1_na),
    .mb   (s1_mb),
    .nb   (s1_nb),
    .res  (lin_res)
  );

  smfa_mul u_mul (
    .clk (clk),
    .en  (s1_vld & s2_rdy),
    .ma  (s1_ma),
    .mb  (s1_mb),
    .res (mul_res)
  );

  always_ff @(posedge clk) begin
    if (s1_vld && s2_rdy) begin
      s2_func <= s1_func;
      s2_lin  <= lin_res;
      s2_mneg <= s1_na ^ s1_nb;
    end
  end

  // A multiply result drops its sign only when it is zero and no flag is up.
  always_comb begin
    out_next = s2_lin;
    if (s2_func == FN_MUL) begin
      out_next       = '0;
      {out_next.whole, out_next.frac} = mul_res.mag;
      out_next.ovf   = mul_res.ovf;
      out_next.unf   = mul_res.unf;
      out_next.neg   = s2_mneg & (mul_res.ovf | mul_res.unf | (mul_res.mag != '0));
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld && s3_rdy) begin
      out_q <= out_next;
    end
  end

  assign m_tdata = {3'b000, out_q.order, out_q.unf, out_q.ovf, out_q.neg,
                    out_q.frac, out_q.whole};

  // The input only stalls when every stage holds a transaction.
  a_full_on_stall : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_vld && s2_vld && m_tvalid))
    else $error("input stalled with an empty stage");

  // A held stage-one transaction keeps its operands while stage two is blocked.
  a_s1_hold : assert property (@(posedge clk) disable iff (rst)
    (s1_vld && !s2_rdy) |=> (s1_vld && $stable(s1_ma) && $stable(s1_mb)))
    else $error("stage one changed while blocked");

  // The compare encoding never takes the unused code.
  a_order_code : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_q.order != 2'b10))
    else $error("illegal compare code");

  // A compare result that is not equal carries no magnitude, sign or flags.
  a_cmp_clean : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_q.order != ORD_EQ) |->
      (out_q.whole == '0 && out_q.frac == '0 && !out_q.neg && !out_q.ovf && !out_q.unf))
    else $error("compare result has a nonzero payload");

endmodule
